[sv/assert_macros.svh]
// Assertion macros for the checker file of the drive and buzzer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tdfb_pkg.sv]
// Types, register codes and melody tables for the track drive failsafe buzzer.
`timescale 1ns / 1ps

package tdfb_pkg;

    localparam int ROM_NOTES  = 39;
    localparam int NOTE_IDX_W = 6;
    localparam int PHASE_W    = 12;
    localparam int AGE_W      = 16;
    localparam int HZ_W       = 15;

    localparam logic [AGE_W-1:0] LINK_TIMEOUT_RST = 16'd300;
    localparam logic [AGE_W-1:0] BEEP_HALF_RST    = 16'd500;
    localparam logic [HZ_W-1:0]  BEEP_FREQ_RST    = 15'd500;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        CFG_LINK_TIMEOUT = 2'd0,
        CFG_BEEP_HALF    = 2'd1,
        CFG_BEEP_FREQ    = 2'd2
    } cfg_idx_t;

    // Drive state after the current word, handed to the sound logic.
    typedef struct packed {
        logic tick;
        dir_t left_dir;
        dir_t right_dir;
        logic melody_en;
    } drive_status_t;

    localparam logic [HZ_W-1:0] NOTE_HZ [ROM_NOTES] = '{
        15'd247, 15'd185, 15'd247, 15'd294, 15'd247, 15'd294, 15'd247, 15'd294, 15'd370,
        15'd294, 15'd370, 15'd294, 15'd370, 15'd440, 15'd220, 15'd294, 15'd220, 15'd294,
        15'd370, 15'd247, 15'd294, 15'd247, 15'd294, 15'd370, 15'd294, 15'd370, 15'd294,
        15'd370, 15'd440, 15'd370, 15'd440, 15'd370, 15'd440, 15'd554, 15'd277, 15'd370,
        15'd277, 15'd370, 15'd440
    };

    // Full note length in ms: floor((60000 / 84) / beats).
    localparam logic [PHASE_W-1:0] NOTE_MS [ROM_NOTES] = '{
        12'd178, 12'd89,  12'd178, 12'd533, 12'd533, 12'd178, 12'd89,  12'd178,
        12'd533, 12'd533, 12'd178, 12'd89,  12'd178, 12'd533, 12'd533, 12'd178,
        12'd89,  12'd178, 12'd860, 12'd178, 12'd178, 12'd89,  12'd178, 12'd533,
        12'd533, 12'd178, 12'd89,  12'd178, 12'd533, 12'd533, 12'd178, 12'd89,
        12'd178, 12'd533, 12'd533, 12'd178, 12'd89,  12'd178, 12'd2380
    };

    // Tone part of each note: floor(full * 88 / 100).
    localparam logic [PHASE_W-1:0] NOTE_TONE_MS [ROM_NOTES] = '{
        12'd156, 12'd78,  12'd156, 12'd469, 12'd469, 12'd156, 12'd78,  12'd156,
        12'd469, 12'd469, 12'd156, 12'd78,  12'd156, 12'd469, 12'd469, 12'd156,
        12'd78,  12'd156, 12'd756, 12'd156, 12'd156, 12'd78,  12'd156, 12'd469,
        12'd469, 12'd156, 12'd78,  12'd156, 12'd469, 12'd469, 12'd156, 12'd78,
        12'd156, 12'd469, 12'd469, 12'd156, 12'd78,  12'd156, 12'd2094
    };

    // Fold a note index onto the table; indexes stay below 64, so one subtract.
    function automatic logic [NOTE_IDX_W-1:0] rom_index(input logic [NOTE_IDX_W-1:0] idx);
        if (idx >= NOTE_IDX_W'(ROM_NOTES)) begin
            return idx - NOTE_IDX_W'(ROM_NOTES);
        end
        return idx;
    endfunction

    function automatic dir_t track_dir(input logic fwd, input logic rev);
        if (fwd && !rev) begin
            return DIR_FWD;
        end
        if (!fwd && rev) begin
            return DIR_REV;
        end
        return DIR_STOP;
    endfunction

endpackage

[sv/tdfb_drive.sv]
// Packet handling, link age, failsafe stop and melody toggle.
`timescale 1ns / 1ps

module tdfb_drive
    import tdfb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                command,
    input  logic                is_manual,
    input  logic                left_fwd,
    input  logic                left_rev,
    input  logic                right_fwd,
    input  logic                right_rev,
    input  logic                aux_toggle,
    input  logic [AGE_W-1:0]    link_timeout,
    output drive_status_t       status,
    output logic                link_lost
);

    dir_t             left_dir_reg, left_dir_next;
    dir_t             right_dir_reg, right_dir_next;
    logic [AGE_W-1:0] packet_age_reg, packet_age_next;
    logic             prev_aux_reg, prev_aux_next;
    logic             melody_en_reg, melody_en_next;
    logic             lost;

    always_comb begin
        left_dir_next   = left_dir_reg;
        right_dir_next  = right_dir_reg;
        packet_age_next = packet_age_reg;
        prev_aux_next   = prev_aux_reg;
        melody_en_next  = melody_en_reg;
        if (!command) begin
            packet_age_next = '0;
            prev_aux_next   = aux_toggle;
            if (aux_toggle && !prev_aux_reg) begin
                melody_en_next = !melody_en_reg;
            end
            if (is_manual) begin
                left_dir_next  = track_dir(left_fwd, left_rev);
                right_dir_next = track_dir(right_fwd, right_rev);
            end else begin
                left_dir_next  = DIR_STOP;
                right_dir_next = DIR_STOP;
            end
        end else if (packet_age_reg != '1) begin
            packet_age_next = packet_age_reg + 1'b1;
        end
        lost = packet_age_next > link_timeout;
        // Failsafe: stale link stops both tracks.
        if (lost) begin
            left_dir_next  = DIR_STOP;
            right_dir_next = DIR_STOP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dir_reg   <= DIR_STOP;
            right_dir_reg  <= DIR_STOP;
            packet_age_reg <= '0;
            prev_aux_reg   <= 1'b0;
            melody_en_reg  <= 1'b0;
        end else if (step_en) begin
            left_dir_reg   <= left_dir_next;
            right_dir_reg  <= right_dir_next;
            packet_age_reg <= packet_age_next;
            prev_aux_reg   <= prev_aux_next;
            melody_en_reg  <= melody_en_next;
        end
    end

    assign status.tick      = command;
    assign status.left_dir  = left_dir_next;
    assign status.right_dir = right_dir_next;
    assign status.melody_en = melody_en_next;
    assign link_lost        = lost;

endmodule

[sv/tdfb_sound.sv]
// Melody sequencer and reverse warning beep.
`timescale 1ns / 1ps

module tdfb_sound
    import tdfb_pkg::*;
#(
    parameter int MELODY_LENGTH = 39
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  drive_status_t      status,
    input  logic [AGE_W-1:0]   beep_half,
    input  logic [HZ_W-1:0]    beep_freq,
    output logic               tone_on,
    output logic [HZ_W-1:0]    tone_hz
);

    localparam logic [NOTE_IDX_W:0] MEL_LEN = (NOTE_IDX_W+1)'(MELODY_LENGTH);

    logic                  playing_reg, playing_next;
    logic [NOTE_IDX_W-1:0] note_idx_reg, note_idx_next;
    logic                  in_tone_reg, in_tone_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  beep_reg, beep_next;
    logic [AGE_W-1:0]      beep_el_reg, beep_el_next;

    logic [NOTE_IDX_W-1:0] rom_sel;
    logic [NOTE_IDX_W-1:0] out_sel;
    logic [PHASE_W-1:0]    tone_len;
    logic [PHASE_W-1:0]    gap_len;
    logic [NOTE_IDX_W:0]   idx_inc;

    always_comb begin
        playing_next  = playing_reg;
        note_idx_next = note_idx_reg;
        in_tone_next  = in_tone_reg;
        phase_next    = phase_reg;
        beep_next     = beep_reg;
        beep_el_next  = beep_el_reg;

        if (status.tick) begin
            if (beep_el_reg != '1) begin
                beep_el_next = beep_el_reg + 1'b1;
            end
            if (playing_reg && phase_reg != '1) begin
                phase_next = phase_reg + 1'b1;
            end
        end

        if (status.melody_en) begin
            beep_next = 1'b0;
            if (!playing_reg) begin
                playing_next  = 1'b1;
                note_idx_next = '0;
                in_tone_next  = 1'b1;
                phase_next    = '0;
            end
        end else if (playing_reg) begin
            playing_next  = 1'b0;
            note_idx_next = '0;
            in_tone_next  = 1'b0;
        end

        rom_sel  = rom_index(note_idx_next);
        tone_len = NOTE_TONE_MS[rom_sel];
        gap_len  = NOTE_MS[rom_sel] - tone_len;
        idx_inc  = {1'b0, note_idx_next} + 1'b1;

        if (status.melody_en) begin
            if (in_tone_next) begin
                if (phase_next >= tone_len) begin
                    in_tone_next = 1'b0;
                    phase_next   = '0;
                end
            end else if (phase_next >= gap_len) begin
                note_idx_next = (idx_inc >= MEL_LEN) ? '0 : idx_inc[NOTE_IDX_W-1:0];
                in_tone_next  = 1'b1;
                phase_next    = '0;
            end
        end else if (status.left_dir == DIR_REV && status.right_dir == DIR_REV) begin
            if (beep_el_next >= beep_half) begin
                beep_next    = !beep_reg;
                beep_el_next = '0;
            end
        end else begin
            beep_next = 1'b0;
        end

        out_sel = rom_index(note_idx_next);
        if (playing_next && in_tone_next) begin
            tone_on = 1'b1;
            tone_hz = NOTE_HZ[out_sel];
        end else if (beep_next) begin
            tone_on = 1'b1;
            tone_hz = beep_freq;
        end else begin
            tone_on = 1'b0;
            tone_hz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg  <= 1'b0;
            note_idx_reg <= '0;
            in_tone_reg  <= 1'b0;
            phase_reg    <= '0;
            beep_reg     <= 1'b0;
            beep_el_reg  <= '0;
        end else if (step_en) begin
            playing_reg  <= playing_next;
            note_idx_reg <= note_idx_next;
            in_tone_reg  <= in_tone_next;
            phase_reg    <= phase_next;
            beep_reg     <= beep_next;
            beep_el_reg  <= beep_el_next;
        end
    end

endmodule

[sv/track_drive_failsafe_buzzer_unit.sv]
// Top level of the track drive with link failsafe and buzzer.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     command, is_manual, buttons, aux_toggle
// m_        out        m_valid / m_ready     pins, tone_on, tone_hz, melody_on, link_lost
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word in, one result word out, one word per cycle: the state update is a single
// pass of logic from the accepted word to the result register, which shows the
// result on the cycle after acceptance. s_ready stays high while the result
// register is empty or being taken, so words follow back to back. A stalled result
// holds and blocks the input side. Reset (aresetn low at a clock edge) clears all state
// but the result payload and loads the register defaults; cfg_ready is always high.

module track_drive_failsafe_buzzer_unit
    import tdfb_pkg::*;
#(
    parameter int MELODY_LENGTH = 39
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_is_manual,
    input  logic        s_left_fwd,
    input  logic        s_left_rev,
    input  logic        s_right_fwd,
    input  logic        s_right_rev,
    input  logic        s_aux_toggle,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_left_pins,
    output logic [1:0]  m_right_pins,
    output logic        m_tone_on,
    output logic [14:0] m_tone_hz,
    output logic        m_melody_on,
    output logic        m_link_lost,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [AGE_W-1:0] link_timeout_reg;
    logic [AGE_W-1:0] beep_half_reg;
    logic [HZ_W-1:0]  beep_freq_reg;

    logic             step_en;
    drive_status_t    status;
    logic             link_lost;
    logic             tone_on;
    logic [HZ_W-1:0]  tone_hz;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       left_pins_reg, right_pins_reg;
    logic             tone_on_reg, melody_on_reg, link_lost_reg;
    logic [HZ_W-1:0]  tone_hz_reg;

    // Accept a word whenever the result register frees up this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_timeout_reg <= LINK_TIMEOUT_RST;
            beep_half_reg    <= BEEP_HALF_RST;
            beep_freq_reg    <= BEEP_FREQ_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINK_TIMEOUT: link_timeout_reg <= cfg_data;
                CFG_BEEP_HALF:    beep_half_reg    <= cfg_data;
                CFG_BEEP_FREQ:    beep_freq_reg    <= cfg_data[HZ_W-1:0];
                default:          ;
            endcase
        end
    end

    tdfb_drive u_drive (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .command      (s_command),
        .is_manual    (s_is_manual),
        .left_fwd     (s_left_fwd),
        .left_rev     (s_left_rev),
        .right_fwd    (s_right_fwd),
        .right_rev    (s_right_rev),
        .aux_toggle   (s_aux_toggle),
        .link_timeout (link_timeout_reg),
        .status       (status),
        .link_lost    (link_lost)
    );

    tdfb_sound #(
        .MELODY_LENGTH (MELODY_LENGTH)
    ) u_sound (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .status    (status),
        .beep_half (beep_half_reg),
        .beep_freq (beep_freq_reg),
        .tone_on   (tone_on),
        .tone_hz   (tone_hz)
    );

    // Result valid: set on accept, drop once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: load only on accept, hold while stalled.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            left_pins_reg  <= status.left_dir;
            right_pins_reg <= status.right_dir;
            tone_on_reg    <= tone_on;
            tone_hz_reg    <= tone_hz;
            melody_on_reg  <= status.melody_en;
            link_lost_reg  <= link_lost;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_left_pins  = left_pins_reg;
    assign m_right_pins = right_pins_reg;
    assign m_tone_on    = tone_on_reg;
    assign m_tone_hz    = tone_hz_reg;
    assign m_melody_on  = melody_on_reg;
    assign m_link_lost  = link_lost_reg;

endmodule

[sv/tdfb_checker.sv]
// Port-level checker for the track drive failsafe buzzer, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_left_pins,
    input logic [1:0]  m_right_pins,
    input logic        m_tone_on,
    input logic [14:0] m_tone_hz,
    input logic        m_melody_on,
    input logic        m_link_lost
);

    // A held result must not be overwritten by a new word.
    `ASSERT_NOW(a_no_accept_on_stall, aclk, aresetn, m_valid && !m_ready, !s_ready,
        "input taken while result stalled")

    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_tone_hz) && $stable(m_left_pins) && $stable(m_right_pins),
        "stalled result changed")

    `ASSERT_NOW(a_silent_zero_hz, aclk, aresetn, m_valid && !m_tone_on, m_tone_hz == 15'd0,
        "silent buzzer with nonzero frequency")

    `ASSERT_NOW(a_failsafe_stop, aclk, aresetn, m_valid && m_link_lost,
        m_left_pins == 2'd0 && m_right_pins == 2'd0, "tracks driven with link lost")

    // Without the melody, sound only comes from the reverse warning.
    `ASSERT_NOW(a_beep_only_reverse, aclk, aresetn, m_valid && m_tone_on && !m_melody_on,
        m_left_pins == 2'd2 && m_right_pins == 2'd2, "beep without both tracks reversing")

endmodule

bind track_drive_failsafe_buzzer_unit tdfb_checker u_tdfb_checker (.*);
